/* rtl/evad_pkg.sv */
// evad_pkg: shared types and constants of the energy voice activity capture block
// used by evad_mul, evad_core and energy_vad_capture; no dependencies
`default_nettype none

package evad_pkg;

    localparam int BUFFER_SAMPLES = 65536;
    localparam int BLOCK_MAX      = 1024;
    localparam int CNT_W          = 17;
    localparam int BLK_W          = 11;
    localparam int QUIET_W        = 20;
    localparam int ESUM_W         = 41;
    localparam int MUL_A_W        = 32;
    localparam int MUL_B_W        = 16;
    localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
    localparam int MUL_STEP_W     = 4;

    localparam logic [CNT_W-1:0]   BUF_LIMIT = CNT_W'(BUFFER_SAMPLES);
    localparam logic [BLK_W-1:0]   BLK_LIMIT = BLK_W'(BLOCK_MAX);
    localparam logic [QUIET_W-1:0] QUIET_MAX = {QUIET_W{1'b1}};
    localparam logic [15:0]        MS_MAX    = 16'hFFFF;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SILENCE   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    localparam logic [14:0] THRESHOLD_RST = 15'd500;
    localparam logic [19:0] SILENCE_RST   = 20'd12800;
    localparam logic [15:0] TIMEOUT_RST   = 16'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_THR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [14:0] energy_threshold;
        logic [19:0] silence_samples;
        logic [15:0] timeout_lim;
    } cfg_t;

    typedef struct packed {
        logic             store_valid;
        logic [15:0]      store_index;
        logic [15:0]      store_sample;
        logic             block_voiced;
        logic             done_res;
        logic             speech_end;
        logic [CNT_W-1:0] length;
    } res_t;

endpackage

`default_nettype wire

/* rtl/evad_mul.sv */
// evad_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// 32 x 16 bit unsigned operands, product after 16 steps; uses evad_pkg
`default_nettype none

module evad_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [evad_pkg::MUL_A_W-1:0] a,
    input  wire logic [evad_pkg::MUL_B_W-1:0] b,
    output logic                             busy,
    output logic [evad_pkg::MUL_P_W-1:0]     prod
);

    logic                             busy_reg;
    logic                             busy_next;
    logic [evad_pkg::MUL_STEP_W-1:0]  step_reg;
    logic [evad_pkg::MUL_STEP_W-1:0]  step_next;
    logic [evad_pkg::MUL_A_W-1:0]     a_reg;
    logic [evad_pkg::MUL_A_W-1:0]     hi_reg;
    logic [evad_pkg::MUL_A_W-1:0]     hi_next;
    logic [evad_pkg::MUL_B_W-1:0]     lo_reg;
    logic [evad_pkg::MUL_B_W-1:0]     lo_next;
    logic [evad_pkg::MUL_A_W:0]       sum;

    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        step_next = step_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next   = sum[evad_pkg::MUL_A_W:1];
            lo_next   = {sum[0], lo_reg[evad_pkg::MUL_B_W-1:1]};
            step_next = step_reg + 1'b1;
            if (step_reg == {evad_pkg::MUL_STEP_W{1'b1}})
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

`default_nettype wire

/* rtl/evad_core.sv */
// evad_core: capture state, block energy and threshold decision sequencer
// uses evad_pkg and two evad_mul serial multipliers
`default_nettype none

module evad_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire evad_pkg::cfg_t cfg,
    input  wire logic           take,
    input  wire logic [1:0]     op,
    input  wire logic [15:0]    sample,
    input  wire logic           block_end,
    input  wire logic           res_ready,
    output logic                idle,
    output logic                res_valid,
    output evad_pkg::res_t      res
);

    evad_pkg::state_t state_reg;
    evad_pkg::state_t state_next;

    logic                         active_reg;
    logic                         active_next;
    logic                         started_reg;
    logic                         started_next;
    logic [evad_pkg::CNT_W-1:0]   captured_reg;
    logic [evad_pkg::CNT_W-1:0]   captured_next;
    logic [evad_pkg::QUIET_W-1:0] quiet_reg;
    logic [evad_pkg::QUIET_W-1:0] quiet_next;
    logic [evad_pkg::ESUM_W-1:0]  esum_reg;
    logic [evad_pkg::ESUM_W-1:0]  esum_next;
    logic [evad_pkg::BLK_W-1:0]   blk_reg;
    logic [evad_pkg::BLK_W-1:0]   blk_next;
    logic [15:0]                  elapsed_reg;
    logic [15:0]                  elapsed_next;
    logic                         bend_reg;
    logic                         bend_next;

    logic        sv_reg;
    logic        sv_next;
    logic [15:0] sidx_reg;
    logic [15:0] sidx_next;
    logic [15:0] ssamp_reg;
    logic [15:0] ssamp_next;
    logic        voiced_reg;
    logic        voiced_next;
    logic        done_reg;
    logic        done_next;
    logic        byvoice_reg;
    logic        byvoice_next;

    logic                          sq_start;
    logic                          sq_busy;
    logic [evad_pkg::MUL_P_W-1:0]  sq_prod;
    logic                          tt_start;
    logic                          tt_busy;
    logic [evad_pkg::MUL_P_W-1:0]  tt_prod;
    logic [evad_pkg::MUL_A_W-1:0]  tt_a;
    logic [evad_pkg::MUL_B_W-1:0]  tt_b;

    logic [15:0]                  mag;
    logic [evad_pkg::BLK_W-1:0]   blk_inc;
    logic [evad_pkg::QUIET_W:0]   quiet_sum;
    logic                         voiced;
    logic                         by_silence;

    assign mag     = sample[15] ? (~sample + 16'd1) : sample;
    assign blk_inc = blk_reg + 1'b1;

    evad_mul u_mul_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .a     ({16'd0, mag}),
        .b     (mag),
        .busy  (sq_busy),
        .prod  (sq_prod)
    );

    evad_mul u_mul_tt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tt_start),
        .a     (tt_a),
        .b     (tt_b),
        .busy  (tt_busy),
        .prod  (tt_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= evad_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        started_next  = started_reg;
        captured_next = captured_reg;
        quiet_next    = quiet_reg;
        esum_next     = esum_reg;
        blk_next      = blk_reg;
        elapsed_next  = elapsed_reg;
        bend_next     = bend_reg;
        sv_next       = sv_reg;
        sidx_next     = sidx_reg;
        ssamp_next    = ssamp_reg;
        voiced_next   = voiced_reg;
        done_next     = done_reg;
        byvoice_next  = byvoice_reg;
        sq_start      = 1'b0;
        tt_start      = 1'b0;
        tt_a          = {17'd0, cfg.energy_threshold};
        tt_b          = {1'b0, cfg.energy_threshold};
        voiced        = {7'd0, esum_reg} > tt_prod;
        quiet_sum     = {1'b0, quiet_reg} + {10'd0, blk_reg};
        by_silence    = 1'b0;
        idle          = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            evad_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (take)
                begin
                    sv_next      = 1'b0;
                    sidx_next    = '0;
                    ssamp_next   = '0;
                    voiced_next  = 1'b0;
                    done_next    = 1'b0;
                    byvoice_next = 1'b0;
                    state_next   = evad_pkg::ST_EMIT;
                    if (op == evad_pkg::OP_START)
                    begin
                        active_next   = 1'b1;
                        started_next  = 1'b0;
                        captured_next = '0;
                        quiet_next    = '0;
                        esum_next     = '0;
                        blk_next      = '0;
                        elapsed_next  = '0;
                    end
                    else if (op == evad_pkg::OP_TICK)
                    begin
                        if (active_reg && elapsed_reg != evad_pkg::MS_MAX)
                        begin
                            elapsed_next = elapsed_reg + 16'd1;
                        end
                    end
                    else if (op == evad_pkg::OP_SAMPLE && active_reg)
                    begin
                        if (captured_reg < evad_pkg::BUF_LIMIT)
                        begin
                            sv_next       = 1'b1;
                            sidx_next     = captured_reg[15:0];
                            ssamp_next    = sample;
                            captured_next = captured_reg + 1'b1;
                        end
                        blk_next   = blk_inc;
                        bend_next  = block_end || (blk_inc >= evad_pkg::BLK_LIMIT);
                        sq_start   = 1'b1;
                        tt_start   = 1'b1;
                        state_next = evad_pkg::ST_SQ;
                    end
                end
            end
            evad_pkg::ST_SQ:
            begin
                if (!sq_busy && !tt_busy)
                begin
                    esum_next = esum_reg + evad_pkg::ESUM_W'(sq_prod[31:0]);
                    if (bend_reg)
                    begin
                        tt_a       = tt_prod[31:0];
                        tt_b       = {5'd0, blk_reg};
                        tt_start   = 1'b1;
                        state_next = evad_pkg::ST_THR;
                    end
                    else
                    begin
                        state_next = evad_pkg::ST_EMIT;
                    end
                end
            end
            evad_pkg::ST_THR:
            begin
                if (!tt_busy)
                begin
                    if (voiced)
                    begin
                        started_next = 1'b1;
                        quiet_next   = '0;
                    end
                    else if (started_reg)
                    begin
                        quiet_next = quiet_sum[evad_pkg::QUIET_W]
                                   ? evad_pkg::QUIET_MAX
                                   : quiet_sum[evad_pkg::QUIET_W-1:0];
                        by_silence = (quiet_next >= cfg.silence_samples);
                    end
                    voiced_next  = voiced;
                    byvoice_next = by_silence;
                    done_next    = by_silence
                                || (captured_reg >= evad_pkg::BUF_LIMIT)
                                || (elapsed_reg >= cfg.timeout_lim);
                    if (done_next)
                    begin
                        active_next = 1'b0;
                    end
                    esum_next  = '0;
                    blk_next   = '0;
                    state_next = evad_pkg::ST_EMIT;
                end
            end
            evad_pkg::ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = evad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = evad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            started_reg  <= 1'b0;
            captured_reg <= '0;
            quiet_reg    <= '0;
            esum_reg     <= '0;
            blk_reg      <= '0;
            elapsed_reg  <= '0;
            bend_reg     <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            started_reg  <= started_next;
            captured_reg <= captured_next;
            quiet_reg    <= quiet_next;
            esum_reg     <= esum_next;
            blk_reg      <= blk_next;
            elapsed_reg  <= elapsed_next;
            bend_reg     <= bend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sv_reg      <= sv_next;
        sidx_reg    <= sidx_next;
        ssamp_reg   <= ssamp_next;
        voiced_reg  <= voiced_next;
        done_reg    <= done_next;
        byvoice_reg <= byvoice_next;
    end

    always_comb
    begin
        res.store_valid    = sv_reg;
        res.store_index    = sidx_reg;
        res.store_sample   = ssamp_reg;
        res.block_voiced   = voiced_reg;
        res.done_res       = done_reg;
        res.speech_end     = byvoice_reg;
        res.length         = captured_reg;
    end

endmodule

`default_nettype wire

/* rtl/energy_vad_capture.sv */
// energy_vad_capture: top level, stream ports, configuration registers, output register
// a start, tick or idle word goes straight to the result state; a sample first waits in
// the square state, and a sample that closes a block then also in the threshold state
// a new word is taken only while the core is idle, so samples are held back by the
// 16-step serial square and the 16-step threshold squared times block length product
// reset: rst_n asynchronous low, capture idle, registers 500 / 12800 / 10000
`default_nettype none

module energy_vad_capture (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample
    input  wire logic [1:0]  s_tuser,   // op
    input  wire logic        s_tlast,   // block_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // store_index, store_sample, block_voiced,
                                        // speech_end, length, zero fill
    output logic [0:0]       m_tuser,   // store_valid
    output logic             m_tlast,   // done_res
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    evad_pkg::cfg_t cfg_reg;
    evad_pkg::res_t core_res;
    evad_pkg::res_t out_res_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           core_idle;
    logic           core_res_valid;
    logic           res_ready;
    logic           take;
    logic [16:0]    out_len_m1;

    assign res_ready = !out_valid_reg || m_tready;
    assign s_tready  = core_idle;
    assign take      = s_tvalid && core_idle;

    evad_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .op        (s_tuser),
        .sample    (s_tdata),
        .block_end (s_tlast),
        .res_ready (res_ready),
        .idle      (core_idle),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_threshold <= evad_pkg::THRESHOLD_RST;
            cfg_reg.silence_samples  <= evad_pkg::SILENCE_RST;
            cfg_reg.timeout_lim      <= evad_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                evad_pkg::REG_THRESHOLD: cfg_reg.energy_threshold <= cfg_data[14:0];
                evad_pkg::REG_SILENCE:   cfg_reg.silence_samples  <= cfg_data;
                evad_pkg::REG_TIMEOUT:   cfg_reg.timeout_lim      <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_valid && res_ready)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.store_valid;
    assign m_tlast  = out_res_reg.done_res;
    assign m_tdata  = {5'd0,
                       out_res_reg.length,
                       out_res_reg.speech_end,
                       out_res_reg.block_voiced,
                       out_res_reg.store_sample,
                       out_res_reg.store_index};

    assign out_len_m1 = out_res_reg.length - 17'd1;

    a_store_index_tracks_length: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[15:0] == out_len_m1[15:0]
    ) else $error("stored index does not match captured length");

    a_voice_ends_capture: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tlast && !m_tdata[32]
    ) else $error("voice end without capture end or on a voiced block");

    a_length_saturates: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[50:34] <= evad_pkg::BUF_LIMIT
    ) else $error("length beyond buffer size");

    a_no_accept_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("second word taken while one is in work");

endmodule

`default_nettype wire
